@@ design/vrpe_pkg.sv @@
// Shared constants, command codes and controller/datapath interface types
// for the voxel ray pick and edit block. No dependencies.
`timescale 1ns / 1ps

package vrpe_pkg;

  // Default geometry
  localparam int GRID_SIDE_DEF       = 32;
  localparam int STEPS_PER_VOXEL_DEF = 32;
  localparam int MAX_VOXEL_DIST_DEF  = 8;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int ORG_W   = 24;
  localparam int DIR_W   = 18;
  localparam int FRAC_W  = 16;
  localparam int VOX_W   = 5;
  localparam int CODE_W  = 8;
  localparam int COORD_W = 8;
  localparam int STEPS_W = 9;

  localparam logic [CODE_W-1:0] PLACE_CODE_RST = 8'd1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PLACE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic clr;      // clearing pass: write air at the sweep address
    logic load;     // capture a new command
    logic march;    // advance the ray one step, check the previous one
    logic wr_rd;    // read the voxel addressed by a write command
    logic wr_fin;   // finish a write command
    logic nop_fin;  // finish an unused command code
  } vrpe_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic hit;
    logic miss;
  } vrpe_stat_t;

endpackage

@@ design/voxel_ray_pick_edit_core.sv @@
// Top level of the voxel ray pick and edit block: controller plus datapath.
// Depends on vrpe_pkg, vrpe_ctrl, vrpe_datapath (and vrpe_ram below it).
`timescale 1ns / 1ps

// Usage
//   Command channel: drive in_* with start high; the command transfers at a
//   rising edge where start is high and busy is low. Command codes: write
//   voxel, place pick, remove pick, and one unused code that only returns
//   an all-zero result.
//   Result channel: every command gives one result, shown for exactly one
//   cycle with out_strobe high. The receiver cannot stall it, so it must
//   take each result in that cycle.
//   Config: cfg_wr_en with cfg_wr_data loads the place code (reset 1);
//   write it only while busy is low and no result is pending.
// Operation
//   After reset the store is swept to air, one entry a cycle, with busy
//   high, over all 2^(3*clog2(GRID_SIDE)) entries (32768 at side 32).
//   Write voxel: busy through a read state and a finish state; the result
//   is registered at the finish. Place/remove: one ray step per cycle
//   through the store's single read port, each step checked after the
//   registered read. A hit at step h ends the march; a miss is shown once
//   step STEPS_PER_VOXEL * MAX_VOXEL_DIST - 1 (255 at defaults) is checked.
//   The edit is written as the result is registered, so the next command
//   already sees it. Unused code: result in the next cycle, busy never rises.

module voxel_ray_pick_edit_core #(
  parameter int GRID_SIDE       = vrpe_pkg::GRID_SIDE_DEF,
  parameter int STEPS_PER_VOXEL = vrpe_pkg::STEPS_PER_VOXEL_DEF,
  parameter int MAX_VOXEL_DIST  = vrpe_pkg::MAX_VOXEL_DIST_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [vrpe_pkg::CMD_W-1:0]          in_cmd,
  input  logic signed [vrpe_pkg::ORG_W-1:0]   in_origin_x,
  input  logic signed [vrpe_pkg::ORG_W-1:0]   in_origin_y,
  input  logic signed [vrpe_pkg::ORG_W-1:0]   in_origin_z,
  input  logic signed [vrpe_pkg::DIR_W-1:0]   in_dir_x,
  input  logic signed [vrpe_pkg::DIR_W-1:0]   in_dir_y,
  input  logic signed [vrpe_pkg::DIR_W-1:0]   in_dir_z,
  input  logic [vrpe_pkg::VOX_W-1:0]          in_voxel_x,
  input  logic [vrpe_pkg::VOX_W-1:0]          in_voxel_y,
  input  logic [vrpe_pkg::VOX_W-1:0]          in_voxel_z,
  input  logic [vrpe_pkg::CODE_W-1:0]         in_block_value,
  input  logic                                cfg_wr_en,
  input  logic [vrpe_pkg::CODE_W-1:0]         cfg_wr_data,
  output logic                                out_strobe,
  output logic                                out_hit,
  output logic signed [vrpe_pkg::COORD_W-1:0] out_hit_x,
  output logic signed [vrpe_pkg::COORD_W-1:0] out_hit_y,
  output logic signed [vrpe_pkg::COORD_W-1:0] out_hit_z,
  output logic [vrpe_pkg::STEPS_W-1:0]        out_steps,
  output logic                                out_edited
);

  // Command and status between the two halves
  vrpe_pkg::vrpe_cmd_t  ctrl_cmd;
  vrpe_pkg::vrpe_stat_t dp_stat;

  // Sequencer: clear sweep, idle, march, write read/finish
  vrpe_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .stat_i (dp_stat),
    .cmd_o  (ctrl_cmd),
    .busy   (busy)
  );

  // Stepper, check stage, store and result registers
  vrpe_datapath #(
    .GRID_SIDE       (GRID_SIDE),
    .STEPS_PER_VOXEL (STEPS_PER_VOXEL),
    .MAX_VOXEL_DIST  (MAX_VOXEL_DIST)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_i          (ctrl_cmd),
    .stat_o         (dp_stat),
    .in_cmd         (in_cmd),
    .in_origin_x    (in_origin_x),
    .in_origin_y    (in_origin_y),
    .in_origin_z    (in_origin_z),
    .in_dir_x       (in_dir_x),
    .in_dir_y       (in_dir_y),
    .in_dir_z       (in_dir_z),
    .in_voxel_x     (in_voxel_x),
    .in_voxel_y     (in_voxel_y),
    .in_voxel_z     (in_voxel_z),
    .in_block_value (in_block_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_strobe     (out_strobe),
    .out_hit        (out_hit),
    .out_hit_x      (out_hit_x),
    .out_hit_y      (out_hit_y),
    .out_hit_z      (out_hit_z),
    .out_steps      (out_steps),
    .out_edited     (out_edited)
  );

`ifndef SYNTHESIS
  // A real command holds the block busy in the following cycle.
  a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd != vrpe_pkg::CMD_NOP) |=> busy)
    else $error("command transfer did not raise busy");

  // The unused code answers in the next cycle.
  a_nop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == vrpe_pkg::CMD_NOP) |=> out_strobe)
    else $error("unused command gave no result");

  // Results only appear once the sequencer is back in idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result while busy");

  // No hit means no coordinates and no step count.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_hit) |->
      (out_steps == '0 && out_hit_x == '0 && out_hit_y == '0 && out_hit_z == '0))
    else $error("miss result carries nonzero fields");

  // A hit at the very first step never edits.
  a_step0_no_edit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_hit && out_steps == '0) |-> !out_edited)
    else $error("edit on a first-step hit");
`endif

endmodule

@@ design/vrpe_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies beyond the package defaults.
`timescale 1ns / 1ps

module vrpe_ram #(
  parameter int WIDTH = vrpe_pkg::CODE_W,
  parameter int DEPTH = 1 << (3 * $clog2(vrpe_pkg::GRID_SIDE_DEF))
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/vrpe_ctrl.sv @@
// Controller state machine for the voxel ray pick and edit block.
// Depends on vrpe_pkg; drives the datapath through vrpe_cmd_t.
`timescale 1ns / 1ps

module vrpe_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [vrpe_pkg::CMD_W-1:0] in_cmd,
  input  vrpe_pkg::vrpe_stat_t       stat_i,
  output vrpe_pkg::vrpe_cmd_t        cmd_o,
  output logic                       busy
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_MARCH  = 3'd2;
  localparam logic [2:0] ST_WR_RD  = 3'd3;
  localparam logic [2:0] ST_WR_FIN = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          unique case (in_cmd) inside
            vrpe_pkg::CMD_WRITE: begin
              state_nxt = ST_WR_RD;
            end
            vrpe_pkg::CMD_PLACE, vrpe_pkg::CMD_REMOVE: begin
              state_nxt = ST_MARCH;
            end
            default: begin
              cmd_o.nop_fin = 1'b1;
            end
          endcase
        end
      end
      ST_MARCH: begin
        cmd_o.march = 1'b1;
        if (stat_i.hit || stat_i.miss) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WR_RD: begin
        cmd_o.wr_rd = 1'b1;
        state_nxt   = ST_WR_FIN;
      end
      ST_WR_FIN: begin
        cmd_o.wr_fin = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

@@ design/vrpe_datapath.sv @@
// Datapath: ray stepper, two-stage voxel check, edit write-back, result
// registers and the voxel store. Depends on vrpe_pkg and vrpe_ram.
`timescale 1ns / 1ps

module vrpe_datapath #(
  parameter int GRID_SIDE       = vrpe_pkg::GRID_SIDE_DEF,
  parameter int STEPS_PER_VOXEL = vrpe_pkg::STEPS_PER_VOXEL_DEF,
  parameter int MAX_VOXEL_DIST  = vrpe_pkg::MAX_VOXEL_DIST_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  vrpe_pkg::vrpe_cmd_t                 cmd_i,
  output vrpe_pkg::vrpe_stat_t                stat_o,
  input  logic [vrpe_pkg::CMD_W-1:0]          in_cmd,
  input  logic signed [vrpe_pkg::ORG_W-1:0]   in_origin_x,
  input  logic signed [vrpe_pkg::ORG_W-1:0]   in_origin_y,
  input  logic signed [vrpe_pkg::ORG_W-1:0]   in_origin_z,
  input  logic signed [vrpe_pkg::DIR_W-1:0]   in_dir_x,
  input  logic signed [vrpe_pkg::DIR_W-1:0]   in_dir_y,
  input  logic signed [vrpe_pkg::DIR_W-1:0]   in_dir_z,
  input  logic [vrpe_pkg::VOX_W-1:0]          in_voxel_x,
  input  logic [vrpe_pkg::VOX_W-1:0]          in_voxel_y,
  input  logic [vrpe_pkg::VOX_W-1:0]          in_voxel_z,
  input  logic [vrpe_pkg::CODE_W-1:0]         in_block_value,
  input  logic                                cfg_wr_en,
  input  logic [vrpe_pkg::CODE_W-1:0]         cfg_wr_data,
  output logic                                out_strobe,
  output logic                                out_hit,
  output logic signed [vrpe_pkg::COORD_W-1:0] out_hit_x,
  output logic signed [vrpe_pkg::COORD_W-1:0] out_hit_y,
  output logic signed [vrpe_pkg::COORD_W-1:0] out_hit_z,
  output logic [vrpe_pkg::STEPS_W-1:0]        out_steps,
  output logic                                out_edited
);

  localparam int ORG_W  = vrpe_pkg::ORG_W;
  localparam int DIR_W  = vrpe_pkg::DIR_W;
  localparam int FRAC_W = vrpe_pkg::FRAC_W;
  localparam int VOX_W  = vrpe_pkg::VOX_W;
  localparam int CODE_W = vrpe_pkg::CODE_W;

  localparam int CW    = $clog2(GRID_SIDE);
  localparam int AW    = 3 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int NSTEP = STEPS_PER_VOXEL * MAX_VOXEL_DIST;
  localparam int SW    = $clog2(NSTEP + 1);
  localparam int DEN   = STEPS_PER_VOXEL * (1 << FRAC_W);
  localparam int RW    = $clog2(DEN) + 2;
  // integer part of the origin plus the farthest travel, with sign
  localparam int QW    = ORG_W - FRAC_W + 2 + $clog2(MAX_VOXEL_DIST + 1);

  localparam logic signed [RW-1:0] DEN_S  = RW'(DEN);
  localparam logic signed [QW-1:0] GSIDE  = QW'(GRID_SIDE);
  localparam logic signed [QW-1:0] Q_ONE  = QW'(1);
  localparam logic [SW-1:0]        LAST_S = SW'(NSTEP - 1);

  function automatic logic in_grid(input logic signed [QW-1:0] x,
                                   input logic signed [QW-1:0] y,
                                   input logic signed [QW-1:0] z);
    return !x[QW-1] && (x < GSIDE) && !y[QW-1] && (y < GSIDE) &&
           !z[QW-1] && (z < GSIDE);
  endfunction

  function automatic logic [AW-1:0] vaddr(input logic signed [QW-1:0] x,
                                          input logic signed [QW-1:0] y,
                                          input logic signed [QW-1:0] z);
    return {z[CW-1:0], y[CW-1:0], x[CW-1:0]};
  endfunction

  logic signed [ORG_W-1:0] org [3];
  logic signed [DIR_W-1:0] dir_in [3];
  logic [VOX_W-1:0]        vox_in [3];

  assign org[0]    = in_origin_x;
  assign org[1]    = in_origin_y;
  assign org[2]    = in_origin_z;
  assign dir_in[0] = in_dir_x;
  assign dir_in[1] = in_dir_y;
  assign dir_in[2] = in_dir_z;
  assign vox_in[0] = in_voxel_x;
  assign vox_in[1] = in_voxel_y;
  assign vox_in[2] = in_voxel_z;

  // Command context
  logic [vrpe_pkg::CMD_W-1:0] cmd_r;
  logic [CODE_W-1:0]          place_code_r;
  logic signed [QW-1:0]       vox_r [3];
  logic [CODE_W-1:0]          val_r;

  // Stepper stage: voxel index, remainder and step count of step s
  logic signed [DIR_W-1:0] dir_r  [3];
  logic signed [QW-1:0]    q_r    [3];
  logic signed [RW-1:0]    r_r    [3];
  logic signed [QW-1:0]    prev_r [3];
  logic [SW-1:0]           s_r;

  // Check stage: step s-1, waiting on the store read
  logic signed [QW-1:0] b_q_r    [3];
  logic signed [QW-1:0] b_prev_r [3];
  logic [SW-1:0]        b_s_r;
  logic                 b_chk_r;
  logic                 b_live_r;

  logic [AW-1:0] clr_cnt_r;

  logic                       out_strobe_r;
  logic                       out_hit_r;
  logic signed [vrpe_pkg::COORD_W-1:0] hit_x_r;
  logic signed [vrpe_pkg::COORD_W-1:0] hit_y_r;
  logic signed [vrpe_pkg::COORD_W-1:0] hit_z_r;
  logic [vrpe_pkg::STEPS_W-1:0] steps_r;
  logic                       edited_r;

  logic signed [RW-1:0] sum    [3];
  logic signed [QW-1:0] q_nxt  [3];
  logic signed [RW-1:0] r_nxt  [3];
  logic signed [QW-1:0] q_init [3];
  logic signed [RW-1:0] r_init [3];
  logic signed [QW-1:0] rep    [3];
  logic                 moved;

  logic [AW-1:0]     mem_waddr;
  logic [CODE_W-1:0] mem_wdata;
  logic              mem_we;
  logic [AW-1:0]     mem_raddr;
  logic [CODE_W-1:0] rd_data;

  logic hit_now;
  logic miss_now;
  logic is_place;
  logic hit_edit;
  logic wr_edit;
  logic fin;

  // Step arithmetic: position = q * DEN + r with 0 <= r < DEN. One step
  // moves r by less than DEN, so a single correction keeps it in range.
  always_comb begin
    moved = (s_r == '0);
    for (int k = 0; k < 3; k++) begin
      sum[k] = r_r[k] + RW'(dir_r[k]);
      if (sum[k][RW-1]) begin
        r_nxt[k] = sum[k] + DEN_S;
        q_nxt[k] = q_r[k] - Q_ONE;
      end else if (sum[k] >= DEN_S) begin
        r_nxt[k] = sum[k] - DEN_S;
        q_nxt[k] = q_r[k] + Q_ONE;
      end else begin
        r_nxt[k] = sum[k];
        q_nxt[k] = q_r[k];
      end
      if (q_r[k] != prev_r[k]) begin
        moved = 1'b1;
      end
      q_init[k] = QW'($signed(org[k][ORG_W-1:FRAC_W]));
      r_init[k] = $signed(RW'(org[k][FRAC_W-1:0]) * RW'(STEPS_PER_VOXEL));
    end
  end

  assign is_place = (cmd_r == vrpe_pkg::CMD_PLACE);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rep[k] = is_place ? b_prev_r[k] : b_q_r[k];
    end
  end

  assign hit_now  = b_live_r && b_chk_r && (rd_data != '0);
  assign miss_now = b_live_r && !hit_now && (b_s_r == LAST_S);

  // Past the first step, the last air voxel was read as air, so a place
  // changes it unless the code is air or the voxel lies outside the grid.
  assign hit_edit = (b_s_r != '0) &&
                    (is_place ? (in_grid(b_prev_r[0], b_prev_r[1], b_prev_r[2]) &&
                                 (place_code_r != '0))
                              : 1'b1);
  assign wr_edit  = in_grid(vox_r[0], vox_r[1], vox_r[2]) && (rd_data != val_r);

  assign fin = cmd_i.nop_fin || cmd_i.wr_fin || (cmd_i.march && (hit_now || miss_now));

  assign stat_o.clr_last = (clr_cnt_r == {AW{1'b1}});
  assign stat_o.hit      = hit_now;
  assign stat_o.miss     = miss_now;

  // Store write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_r;
    mem_wdata = '0;
    if (cmd_i.clr) begin
      mem_we = 1'b1;
    end else if (cmd_i.march && hit_now && hit_edit) begin
      mem_we    = 1'b1;
      mem_waddr = vaddr(rep[0], rep[1], rep[2]);
      mem_wdata = is_place ? place_code_r : '0;
    end else if (cmd_i.wr_fin && wr_edit) begin
      mem_we    = 1'b1;
      mem_waddr = vaddr(vox_r[0], vox_r[1], vox_r[2]);
      mem_wdata = val_r;
    end
  end

  assign mem_raddr = cmd_i.wr_rd ? vaddr(vox_r[0], vox_r[1], vox_r[2])
                                 : vaddr(q_r[0], q_r[1], q_r[2]);

  vrpe_ram #(
    .WIDTH (CODE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (rd_data)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      place_code_r <= vrpe_pkg::PLACE_CODE_RST;
      clr_cnt_r    <= '0;
      b_live_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        place_code_r <= cfg_wr_data;
      end
      if (cmd_i.clr) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      b_live_r     <= cmd_i.march;
      out_strobe_r <= fin;
    end
  end

  // Command capture and ray stepping
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      cmd_r <= in_cmd;
      val_r <= in_block_value;
      s_r   <= '0;
      for (int k = 0; k < 3; k++) begin
        dir_r[k]  <= dir_in[k];
        q_r[k]    <= q_init[k];
        r_r[k]    <= r_init[k];
        prev_r[k] <= '0;
        vox_r[k]  <= $signed({{(QW - VOX_W){1'b0}}, vox_in[k]});
      end
    end else if (cmd_i.march) begin
      s_r     <= s_r + SW'(1);
      b_s_r   <= s_r;
      b_chk_r <= moved && in_grid(q_r[0], q_r[1], q_r[2]);
      for (int k = 0; k < 3; k++) begin
        q_r[k]      <= q_nxt[k];
        r_r[k]      <= r_nxt[k];
        prev_r[k]   <= q_r[k];
        b_q_r[k]    <= q_r[k];
        b_prev_r[k] <= prev_r[k];
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd_i.march && hit_now) begin
      out_hit_r <= 1'b1;
      hit_x_r   <= vrpe_pkg::COORD_W'(rep[0]);
      hit_y_r   <= vrpe_pkg::COORD_W'(rep[1]);
      hit_z_r   <= vrpe_pkg::COORD_W'(rep[2]);
      steps_r   <= vrpe_pkg::STEPS_W'(b_s_r);
      edited_r  <= hit_edit;
    end else if (fin) begin
      out_hit_r <= 1'b0;
      hit_x_r   <= '0;
      hit_y_r   <= '0;
      hit_z_r   <= '0;
      steps_r   <= '0;
      edited_r  <= cmd_i.wr_fin && wr_edit;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_hit    = out_hit_r;
  assign out_hit_x  = hit_x_r;
  assign out_hit_y  = hit_y_r;
  assign out_hit_z  = hit_z_r;
  assign out_steps  = steps_r;
  assign out_edited = edited_r;

endmodule

@@ tb/sv/voxel_ray_pick_edit_core_tb.sv @@
// Self-checking testbench for voxel_ray_pick_edit_core: directed and random
// write, place, remove and unused commands, checked against a local model.
// Depends on vrpe_pkg and the RTL under design/.
`timescale 1ns / 1ps

module voxel_ray_pick_edit_core_tb;
  import vrpe_pkg::*;

  localparam int GRID_SIDE       = GRID_SIDE_DEF;
  localparam int STEPS_PER_VOXEL = STEPS_PER_VOXEL_DEF;
  localparam int MAX_VOXEL_DIST  = MAX_VOXEL_DIST_DEF;
  localparam int GRID_CELLS      = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int MARCH_STEPS     = STEPS_PER_VOXEL * MAX_VOXEL_DIST;

  // Q.16 helpers for building rays
  localparam int ONE  = 1 << FRAC_W;
  localparam int HALF = ONE / 2;
  localparam int TICK = ONE / STEPS_PER_VOXEL;  // one march step along a unit axis

  // Dense block cluster that random picks aim at
  localparam int CLUSTER_LO = 10;
  localparam int CLUSTER_SZ = 8;

  localparam int ITEMS_PER_PHASE = 80;
  localparam int NUM_PHASES      = 5;
  localparam int TAIL_CYCLES     = 300;      // beyond the longest miss latency
  localparam int CYCLE_LIMIT     = 1000000;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ORG_W-1:0]  origin_x;
    logic [ORG_W-1:0]  origin_y;
    logic [ORG_W-1:0]  origin_z;
    logic [DIR_W-1:0]  dir_x;
    logic [DIR_W-1:0]  dir_y;
    logic [DIR_W-1:0]  dir_z;
    logic [VOX_W-1:0]  voxel_x;
    logic [VOX_W-1:0]  voxel_y;
    logic [VOX_W-1:0]  voxel_z;
    logic [CODE_W-1:0] block_value;
  } pick_cmd_t;

  typedef struct packed {
    logic               hit;
    logic [COORD_W-1:0] hit_x;
    logic [COORD_W-1:0] hit_y;
    logic [COORD_W-1:0] hit_z;
    logic [STEPS_W-1:0] steps;
    logic               edited;
  } pick_res_t;

  // Scoreboard: keeps a shadow voxel grid and place code, predicts the result
  // of every transferred command and checks the results in order.
  class pick_scoreboard;
    bit [CODE_W-1:0]   grid [GRID_CELLS];
    logic [CODE_W-1:0] place_code;
    pick_res_t         expected_q [$];
    int                fail_cnt;

    function new();
      place_code = PLACE_CODE_RST;
      fail_cnt   = 0;
    endfunction

    function void set_place_code(logic [CODE_W-1:0] code);
      place_code = code;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit in_grid(longint x, longint y, longint z);
      return x >= 0 && x < GRID_SIDE && y >= 0 && y < GRID_SIDE &&
             z >= 0 && z < GRID_SIDE;
    endfunction

    function int cell_of(longint x, longint y, longint z);
      return int'(x + GRID_SIDE * (y + GRID_SIDE * z));
    endfunction

    // Writes outside the grid are dropped; report whether the cell changed.
    function bit store_voxel(longint x, longint y, longint z, logic [CODE_W-1:0] code);
      int idx;
      if (!in_grid(x, y, z)) return 1'b0;
      idx = cell_of(x, y, z);
      if (grid[idx] == code) return 1'b0;
      grid[idx] = code;
      return 1'b1;
    endfunction

    function void note_cmd(pick_cmd_t c);
      pick_res_t r;
      longint    org [3];
      longint    dir [3];
      longint    cur [3];
      longint    prev [3];
      longint    rep [3];
      longint    num;
      longint    den;
      bit        moved;
      bit        found;
      bit [CODE_W-1:0] code_here;
      r     = '0;
      prev  = '{0, 0, 0};
      found = 1'b0;
      den   = longint'(STEPS_PER_VOXEL) * ONE;
      case (c.cmd)
        CMD_WRITE: begin
          r.edited = store_voxel(longint'(c.voxel_x), longint'(c.voxel_y),
                                 longint'(c.voxel_z), c.block_value);
        end
        CMD_PLACE, CMD_REMOVE: begin
          // Scale the origin so that step s sits at origin*N + s*dir.
          org[0] = longint'($signed(c.origin_x)) * STEPS_PER_VOXEL;
          org[1] = longint'($signed(c.origin_y)) * STEPS_PER_VOXEL;
          org[2] = longint'($signed(c.origin_z)) * STEPS_PER_VOXEL;
          dir[0] = longint'($signed(c.dir_x));
          dir[1] = longint'($signed(c.dir_y));
          dir[2] = longint'($signed(c.dir_z));
          for (int s = 0; s < MARCH_STEPS && !found; s++) begin
            moved = (s == 0);
            for (int k = 0; k < 3; k++) begin
              num    = org[k] + longint'(s) * dir[k];
              cur[k] = num / den;
              if (num % den != 0 && num < 0) cur[k] = cur[k] - 1;
              if (cur[k] != prev[k]) moved = 1'b1;
            end
            if (moved) begin
              code_here = in_grid(cur[0], cur[1], cur[2]) ?
                          grid[cell_of(cur[0], cur[1], cur[2])] : '0;
              if (code_here != 0) begin
                found = 1'b1;
                if (c.cmd == CMD_PLACE) rep = prev;
                else rep = cur;
                r.hit   = 1'b1;
                r.hit_x = rep[0][COORD_W-1:0];
                r.hit_y = rep[1][COORD_W-1:0];
                r.hit_z = rep[2][COORD_W-1:0];
                r.steps = STEPS_W'(s);
                if (s > 0)
                  r.edited = store_voxel(rep[0], rep[1], rep[2],
                                         (c.cmd == CMD_PLACE) ? place_code : '0);
              end else begin
                prev = cur;
              end
            end
          end
        end
        default: ;  // unused code: all-zero result
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(pick_res_t got);
      pick_res_t want;
      if (expected_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result: hit %0d xyz %0d,%0d,%0d steps %0d edited %0d",
                   got.hit, $signed(got.hit_x), $signed(got.hit_y), $signed(got.hit_z),
                   got.steps, got.edited);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("mismatch: expected hit %0d xyz %0d,%0d,%0d steps %0d edited %0d",
                   want.hit, $signed(want.hit_x), $signed(want.hit_y),
                   $signed(want.hit_z), want.steps, want.edited,
                   " / got hit %0d xyz %0d,%0d,%0d steps %0d edited %0d",
                   got.hit, $signed(got.hit_x), $signed(got.hit_y),
                   $signed(got.hit_z), got.steps, got.edited);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------
  // Block ports. Every input starts at a known value.
  // ---------------------------------------------------------------------
  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                start          = 1'b0;
  logic                busy;
  logic [CMD_W-1:0]    in_cmd         = '0;
  logic [ORG_W-1:0]    in_origin_x    = '0;
  logic [ORG_W-1:0]    in_origin_y    = '0;
  logic [ORG_W-1:0]    in_origin_z    = '0;
  logic [DIR_W-1:0]    in_dir_x       = '0;
  logic [DIR_W-1:0]    in_dir_y       = '0;
  logic [DIR_W-1:0]    in_dir_z       = '0;
  logic [VOX_W-1:0]    in_voxel_x     = '0;
  logic [VOX_W-1:0]    in_voxel_y     = '0;
  logic [VOX_W-1:0]    in_voxel_z     = '0;
  logic [CODE_W-1:0]   in_block_value = '0;
  logic                cfg_wr_en      = 1'b0;
  logic [CODE_W-1:0]   cfg_wr_data    = '0;
  logic                out_strobe;
  logic                out_hit;
  logic [COORD_W-1:0]  out_hit_x;
  logic [COORD_W-1:0]  out_hit_y;
  logic [COORD_W-1:0]  out_hit_z;
  logic [STEPS_W-1:0]  out_steps;
  logic                out_edited;

  pick_scoreboard sb;
  int             cycle_cnt = 0;
  pick_cmd_t      last_write;
  bit             have_write = 1'b0;

  voxel_ray_pick_edit_core #(
    .GRID_SIDE       (GRID_SIDE),
    .STEPS_PER_VOXEL (STEPS_PER_VOXEL),
    .MAX_VOXEL_DIST  (MAX_VOXEL_DIST)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_origin_x    (in_origin_x),
    .in_origin_y    (in_origin_y),
    .in_origin_z    (in_origin_z),
    .in_dir_x       (in_dir_x),
    .in_dir_y       (in_dir_y),
    .in_dir_z       (in_dir_z),
    .in_voxel_x     (in_voxel_x),
    .in_voxel_y     (in_voxel_y),
    .in_voxel_z     (in_voxel_z),
    .in_block_value (in_block_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_strobe     (out_strobe),
    .out_hit        (out_hit),
    .out_hit_x      (out_hit_x),
    .out_hit_y      (out_hit_y),
    .out_hit_z      (out_hit_z),
    .out_steps      (out_steps),
    .out_edited     (out_edited)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // Results cannot be held off: take every strobed result at the edge that
  // ends its cycle. Field order of the concatenation matches pick_res_t.
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1)
      sb.check_result({out_hit, out_hit_x, out_hit_y, out_hit_z, out_steps, out_edited});
  end

  // Give up on a hang.
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------

  // Every field random, so that unused fields also toggle.
  function automatic pick_cmd_t rand_fields();
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(pick_cmd_t)-1:0];
  endfunction

  function automatic pick_cmd_t mk_pick(logic [CMD_W-1:0] cmd, int ox, int oy, int oz,
                                        int dx, int dy, int dz);
    pick_cmd_t c;
    c          = rand_fields();
    c.cmd      = cmd;
    c.origin_x = ORG_W'(ox);
    c.origin_y = ORG_W'(oy);
    c.origin_z = ORG_W'(oz);
    c.dir_x    = DIR_W'(dx);
    c.dir_y    = DIR_W'(dy);
    c.dir_z    = DIR_W'(dz);
    return c;
  endfunction

  function automatic pick_cmd_t mk_write(int x, int y, int z, int code);
    pick_cmd_t c;
    c             = rand_fields();
    c.cmd         = CMD_WRITE;
    c.voxel_x     = VOX_W'(x);
    c.voxel_y     = VOX_W'(y);
    c.voxel_z     = VOX_W'(z);
    c.block_value = CODE_W'(code);
    return c;
  endfunction

  // Ray origin a few voxels around the cluster, random fraction.
  function automatic logic [ORG_W-1:0] near_cluster_q16();
    int v;
    v = (CLUSTER_LO - 6 + int'($urandom_range(CLUSTER_SZ + 11))) * ONE +
        int'($urandom_range(ONE - 1));
    return ORG_W'(v);
  endfunction

  // Roughly unit direction component, not normalized.
  function automatic logic [DIR_W-1:0] rand_dir();
    return DIR_W'($urandom_range(2 * ONE) - ONE);
  endfunction

  function automatic pick_cmd_t random_cmd();
    pick_cmd_t   c;
    int unsigned roll;
    c    = rand_fields();
    roll = $urandom_range(99);
    if (roll < 8) begin
      // Noise: unused code, or a raw ray that mostly starts far outside.
      if (roll < 3) c.cmd = CMD_NOP;
      else c.cmd = roll[0] ? CMD_PLACE : CMD_REMOVE;
    end else if (roll < 45) begin
      c.cmd = CMD_WRITE;
      if ($urandom_range(9) < 8) begin
        c.voxel_x = VOX_W'(CLUSTER_LO + $urandom_range(CLUSTER_SZ - 1));
        c.voxel_y = VOX_W'(CLUSTER_LO + $urandom_range(CLUSTER_SZ - 1));
        c.voxel_z = VOX_W'(CLUSTER_LO + $urandom_range(CLUSTER_SZ - 1));
      end
      if ($urandom_range(4) == 0) c.block_value = '0;
      // Repeat the previous write now and then to hit the unchanged case.
      if (have_write && $urandom_range(9) == 0) c = last_write;
      last_write = c;
      have_write = 1'b1;
    end else begin
      c.cmd = $urandom_range(1) ? CMD_PLACE : CMD_REMOVE;
      if ($urandom_range(9) == 0) begin
        c.origin_x = ORG_W'($urandom_range(GRID_SIDE * ONE - 1));
        c.origin_y = ORG_W'($urandom_range(GRID_SIDE * ONE - 1));
        c.origin_z = ORG_W'($urandom_range(GRID_SIDE * ONE - 1));
      end else begin
        c.origin_x = near_cluster_q16();
        c.origin_y = near_cluster_q16();
        c.origin_z = near_cluster_q16();
      end
      if ($urandom_range(3) == 0) begin
        // axis-aligned unit ray
        c.dir_x = '0;
        c.dir_y = '0;
        c.dir_z = '0;
        case ($urandom_range(2))
          0:       c.dir_x = $urandom_range(1) ? DIR_W'(ONE) : DIR_W'(-ONE);
          1:       c.dir_y = $urandom_range(1) ? DIR_W'(ONE) : DIR_W'(-ONE);
          default: c.dir_z = $urandom_range(1) ? DIR_W'(ONE) : DIR_W'(-ONE);
        endcase
      end else begin
        c.dir_x = rand_dir();
        c.dir_y = rand_dir();
        c.dir_z = rand_dir();
      end
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------
  // Drivers. Each task is entered at a rising edge and returns at one.
  // ---------------------------------------------------------------------

  // Present one command and hold it until it transfers. Start is left high
  // so that a back-to-back command follows without a dip.
  task automatic send_cmd(input pick_cmd_t c, input bit calm);
    if (!calm && $urandom_range(99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    start          <= 1'b1;
    in_cmd         <= c.cmd;
    in_origin_x    <= c.origin_x;
    in_origin_y    <= c.origin_y;
    in_origin_z    <= c.origin_z;
    in_dir_x       <= c.dir_x;
    in_dir_y       <= c.dir_y;
    in_dir_z       <= c.dir_z;
    in_voxel_x     <= c.voxel_x;
    in_voxel_y     <= c.voxel_y;
    in_voxel_z     <= c.voxel_z;
    in_block_value <= c.block_value;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_cmd(c);
  endtask

  // Drain all outstanding results, let the block settle, then load the
  // place code.
  task automatic load_place_code(input logic [CODE_W-1:0] code);
    start <= 1'b0;
    while (sb.pending() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= code;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_place_code(code);
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    logic [CODE_W-1:0] phase_code [NUM_PHASES];
    pick_cmd_t         c;
    sb = new();
    phase_code[0] = 8'h00;                         // place writes air: never an edit
    phase_code[1] = 8'hFF;
    phase_code[2] = CODE_W'($urandom_range(255));
    phase_code[3] = CODE_W'($urandom_range(255));
    phase_code[4] = PLACE_CODE_RST;

    // Hold reset, then wait out the clearing sweep.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (busy !== 1'b1) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);

    // Directed part, reset place code.
    c = rand_fields();
    c.cmd = CMD_NOP;
    send_cmd(c, 1'b0);
    // empty grid: a miss
    send_cmd(mk_pick(CMD_PLACE, 16*ONE + HALF, 16*ONE + HALF, 16*ONE + HALF, ONE, 0, 0), 1'b0);
    send_cmd(mk_write(20, 16, 16, 5), 1'b0);
    // same value again: no change
    send_cmd(mk_write(20, 16, 16, 5), 1'b0);
    // place in front of the block, then remove what was placed
    send_cmd(mk_pick(CMD_PLACE, 16*ONE + HALF, 16*ONE + HALF, 16*ONE + HALF, ONE, 0, 0), 1'b0);
    send_cmd(mk_pick(CMD_REMOVE, 16*ONE + HALF, 16*ONE + HALF, 16*ONE + HALF, ONE, 0, 0), 1'b0);
    // origin inside a block: hit at the first step, no edit
    send_cmd(mk_pick(CMD_PLACE, 20*ONE + HALF, 16*ONE + HALF, 16*ONE + HALF, ONE, 0, 0), 1'b0);
    send_cmd(mk_pick(CMD_REMOVE, 20*ONE + HALF, 16*ONE + HALF, 16*ONE + HALF, ONE, 0, 0), 1'b0);
    // grid corners
    send_cmd(mk_write(0, 0, 0, 255), 1'b0);
    send_cmd(mk_write(31, 31, 31, 8'h80), 1'b0);
    // ray from outside: the last air voxel lies outside, so the place is dropped
    send_cmd(mk_pick(CMD_PLACE, -3*ONE, HALF, HALF, ONE, 0, 0), 1'b0);
    // enter the far corner from outside and clear it
    send_cmd(mk_pick(CMD_REMOVE, 38*ONE + HALF, 31*ONE + HALF, 31*ONE + HALF, -ONE, 0, 0),
             1'b0);
    // crossing on the very last step of the march
    send_cmd(mk_pick(CMD_PLACE, 12*ONE + TICK, 16*ONE + HALF, 16*ONE + HALF, ONE, 0, 0), 1'b0);
    // extreme origins and out-of-range directions
    send_cmd(mk_pick(CMD_REMOVE, -(1 << 23), -(1 << 23), -(1 << 23), -ONE, -ONE, -ONE), 1'b0);
    send_cmd(mk_pick(CMD_PLACE, (1 << 23) - 1, (1 << 23) - 1, (1 << 23) - 1,
                     (1 << 17) - 1, (1 << 17) - 1, (1 << 17) - 1), 1'b0);
    send_cmd(mk_pick(CMD_REMOVE, 26*ONE + HALF, 16*ONE + HALF, 16*ONE + HALF,
                     -(1 << 17), 0, 0), 1'b0);
    // zero direction: only the starting voxel is looked at
    send_cmd(mk_pick(CMD_PLACE, 5*ONE + HALF, 5*ONE + HALF, 5*ONE + HALF, 0, 0, 0), 1'b0);
    send_cmd(mk_pick(CMD_PLACE, HALF, HALF, HALF, 0, 0, 0), 1'b0);
    // diagonal ray
    send_cmd(mk_write(10, 10, 10, 7), 1'b0);
    send_cmd(mk_pick(CMD_PLACE, 8*ONE + HALF, 8*ONE + HALF, 8*ONE + HALF,
                     37837, 37837, 37837), 1'b0);
    // air into air: no change
    send_cmd(mk_write(3, 4, 5, 0), 1'b0);

    // Random phases, one place code each; the middle phase runs without gaps.
    for (int p = 0; p < NUM_PHASES; p++) begin
      load_place_code(phase_code[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_cmd(random_cmd(), p == 2);
    end

    // Drain, then watch for stray results.
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.fail_cnt == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
